FILE: rtl/sdq_pkg.sv
// shared types and constants for the sorted deadline queue
`default_nettype none

package sdq_pkg;

  localparam int unsigned TickW = 32;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_QUERY   = 2'd1,
    OP_POP     = 2'd2,
    OP_IDLE    = 2'd3
  } opcode_e;

  // what a cell reports about its own entry
  typedef enum logic [2:0] {
    HIT_NONE,
    HIT_EXP,
    HIT_EQ,
    HIT_GT,
    HIT_END,
    HIT_STOP
  } hit_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_REMOVE,
    ACT_INSERT
  } act_e;

  typedef enum logic {
    MODE_REQ,
    MODE_POP
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    act_e              act;
    logic [TickW-1:0]  now;
    logic [TickW-1:0]  next;
  } cmd_t;

  typedef struct packed {
    logic found;
    hit_e kind;
  } scan_t;

endpackage

`default_nettype wire

FILE: rtl/sdq_cell.sv
// one storage cell of the deadline chain with its compare and shift logic
`default_nettype none

module sdq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sdq_pkg::cmd_t                cmd_i,
  input  sdq_pkg::scan_t               scan_i,
  output sdq_pkg::scan_t               scan_o,
  input  logic [sdq_pkg::TickW-1:0]    left_entry_i,
  input  logic                         left_valid_i,
  input  logic [sdq_pkg::TickW-1:0]    right_entry_i,
  input  logic                         right_valid_i,
  output logic [sdq_pkg::TickW-1:0]    entry_o,
  output logic                         valid_o
);

  localparam int unsigned W = sdq_pkg::TickW;

  logic [W-1:0]    entry_q, entry_d;
  logic            valid_q, valid_d;
  logic [W-1:0]    now_span;
  logic [W-1:0]    next_span;
  sdq_pkg::hit_e   kind;
  logic            hit;

  always_comb begin
    now_span  = entry_q - cmd_i.now;
    next_span = entry_q - cmd_i.next;
    kind      = sdq_pkg::HIT_END;
    if (valid_q) begin
      if (cmd_i.mode == sdq_pkg::MODE_POP) begin
        if (now_span[W-1] || (now_span == '0)) begin
          kind = sdq_pkg::HIT_EXP;
        end else begin
          kind = sdq_pkg::HIT_STOP;
        end
      end else begin
        priority if (now_span[W-1]) begin
          kind = sdq_pkg::HIT_EXP;
        end else if (entry_q == cmd_i.next) begin
          kind = sdq_pkg::HIT_EQ;
        end else if (!next_span[W-1] && (next_span != '0)) begin
          kind = sdq_pkg::HIT_GT;
        end else begin
          kind = sdq_pkg::HIT_NONE;
        end
      end
    end
  end

  assign hit = (kind != sdq_pkg::HIT_NONE);

  always_comb begin
    if (scan_i.found) begin
      scan_o = scan_i;
    end else begin
      scan_o.found = hit;
      scan_o.kind  = kind;
    end
  end

  // cells past the first hit follow their neighbour, the hit cell takes the action
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    unique case (cmd_i.act)
      sdq_pkg::ACT_REMOVE: begin
        if (scan_i.found || hit) begin
          entry_d = right_entry_i;
          valid_d = right_valid_i;
        end
      end
      sdq_pkg::ACT_INSERT: begin
        if (scan_i.found) begin
          entry_d = left_entry_i;
          valid_d = left_valid_i;
        end else if (hit) begin
          entry_d = cmd_i.next;
          valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/sdq_tick_calc.sv
// delay to deadline conversion: ceiling division by the tick period via reciprocal
`default_nettype none

module sdq_tick_calc #(
  parameter int unsigned TICK_PERIOD_MS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sdq_pkg::TickW-1:0]    delay_i,
  input  logic [sdq_pkg::TickW-1:0]    now_i,
  output logic                         done_o,
  output logic [sdq_pkg::TickW-1:0]    next_o
);

  localparam int unsigned W = sdq_pkg::TickW;
  localparam logic [2*W-1:0] RecipFull = (64'd1 << W) / 64'(TICK_PERIOD_MS);
  localparam logic [W-1:0]   Recip     = RecipFull[W-1:0];
  localparam logic [W-1:0]   Div       = W'(TICK_PERIOD_MS);
  localparam bit             DivOne    = (TICK_PERIOD_MS == 1);

  logic           v1_q, v2_q, v3_q, v4_q;

  logic [2*W-1:0] s1_prod_q, s1_prod_d;
  logic [W-1:0]   s1_x_q, s1_now_q;

  logic [W-1:0]   s2_q0_d;
  logic [W-1:0]   s2_q0_q, s2_qd_q, s2_qd_d, s2_x_q, s2_now_q;

  logic [W-1:0]   s3_rem;
  logic           s3_ge, s3_nz;
  logic [1:0]     s3_adj_d, s3_adj_q;
  logic [W-1:0]   s3_q0_q, s3_now_q;

  logic [W-1:0]   next_q, next_d;

  // quotient estimate, low by at most one
  assign s1_prod_d = (2*W)'(delay_i) * (2*W)'(Recip);
  assign s2_q0_d   = DivOne ? s1_x_q : s1_prod_q[2*W-1:W];
  assign s2_qd_d   = s2_q0_d * Div;

  // correction plus rounding up on a non-zero remainder
  always_comb begin
    s3_rem   = s2_x_q - s2_qd_q;
    s3_ge    = (s3_rem >= Div);
    s3_nz    = s3_ge ? (s3_rem != Div) : (s3_rem != '0);
    s3_adj_d = {1'b0, s3_ge} + {1'b0, s3_nz};
  end

  assign next_d = s3_now_q + s3_q0_q + W'(s3_adj_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_prod_q <= s1_prod_d;
      s1_x_q    <= delay_i;
      s1_now_q  <= now_i;
    end
    if (v1_q) begin
      s2_q0_q  <= s2_q0_d;
      s2_qd_q  <= s2_qd_d;
      s2_x_q   <= s1_x_q;
      s2_now_q <= s1_now_q;
    end
    if (v2_q) begin
      s3_adj_q <= s3_adj_d;
      s3_q0_q  <= s2_q0_q;
      s3_now_q <= s2_now_q;
    end
    if (v3_q) begin
      next_q <= next_d;
    end
  end

  assign done_o = v4_q;
  assign next_o = next_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_deadline_queue.sv
// top level: sorted deadline queue built from a chain of compare-and-shift cells
//
//   beat      direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    opcode_i, now_tick_i, delay_ms_i
//   out       output     out_valid_o / out_ready_i  wait_ticks_o, last_span_o,
//                                                   entry_count_o, inserted_o, overflow_o
//   cfg       input      cfg_we_i                   cfg_wdata_i (empty_wait)
//
// query and unused opcodes go straight from idle to done; pop and request remove E deadlines,
// where E is the number of expired deadlines removed, one per cycle by the cell chain;
// a request first passes through the reciprocal divider pipeline.
// one beat is in flight at a time; a finished result waits in the output register
// while the next beat is taken. reset empties the queue and sets empty_wait to 100.
`default_nettype none

module sorted_deadline_queue #(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned TICK_PERIOD_MS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [31:0]                now_tick_i,
  input  logic [31:0]                delay_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                wait_ticks_o,
  output logic signed [31:0]         last_span_o,
  output logic [4:0]                 entry_count_o,
  output logic                       inserted_o,
  output logic                       overflow_o
);

  localparam int unsigned W  = sdq_pkg::TickW;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_REQ,
    S_POP,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [W-1:0]    now_q, now_d;
  logic [W-1:0]    res_wait_q, res_wait_d;
  logic [W-1:0]    res_span_q, res_span_d;
  logic            res_ins_q, res_ins_d;
  logic            res_ovf_q, res_ovf_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_wait_q, out_wait_d;
  logic [W-1:0]    out_span_q, out_span_d;
  logic [4:0]      out_count_q, out_count_d;
  logic            out_ins_q, out_ins_d;
  logic            out_ovf_q, out_ovf_d;
  logic [W-1:0]    empty_wait_q;

  logic            accept;
  logic            full;
  logic [W-1:0]    head_span_in;
  logic [W-1:0]    head_span;
  logic            calc_done;
  logic [W-1:0]    calc_next;

  sdq_pkg::cmd_t   cmd;
  sdq_pkg::act_e   act;
  sdq_pkg::scan_t  scan_w [DEPTH+1];
  logic [W-1:0]    entry_w [DEPTH];
  logic            valid_w [DEPTH];
  logic [W-1:0]    left_entry [DEPTH];
  logic            left_valid [DEPTH];
  logic [W-1:0]    right_entry [DEPTH];
  logic            right_valid [DEPTH];

  assign accept = in_valid_i && in_ready_o;
  assign full   = (count_q == CW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_wait_q <= 32'd100;
    end else if (cfg_we_i) begin
      empty_wait_q <= cfg_wdata_i;
    end
  end

  sdq_tick_calc #(
    .TICK_PERIOD_MS (TICK_PERIOD_MS)
  ) u_tick_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (opcode_i == sdq_pkg::OP_REQUEST)),
    .delay_i (delay_ms_i),
    .now_i   (now_tick_i),
    .done_o  (calc_done),
    .next_o  (calc_next)
  );

  assign scan_w[0] = '{found: 1'b0, kind: sdq_pkg::HIT_NONE};

  always_comb begin
    cmd.mode = (state_q == S_POP) ? sdq_pkg::MODE_POP : sdq_pkg::MODE_REQ;
    cmd.act  = act;
    cmd.now  = now_q;
    cmd.next = calc_next;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_entry[i] = '0;
      assign left_valid[i] = 1'b0;
    end else begin : g_body
      assign left_entry[i] = entry_w[i-1];
      assign left_valid[i] = valid_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry[i] = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner
      assign right_entry[i] = entry_w[i+1];
      assign right_valid[i] = valid_w[i+1];
    end

    sdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .scan_i        (scan_w[i]),
      .scan_o        (scan_w[i+1]),
      .left_entry_i  (left_entry[i]),
      .left_valid_i  (left_valid[i]),
      .right_entry_i (right_entry[i]),
      .right_valid_i (right_valid[i]),
      .entry_o       (entry_w[i]),
      .valid_o       (valid_w[i])
    );
  end

  assign head_span_in = entry_w[0] - now_tick_i;
  assign head_span    = entry_w[0] - now_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    now_d       = now_q;
    res_wait_d  = res_wait_q;
    res_span_d  = res_span_q;
    res_ins_d   = res_ins_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q;
    out_wait_d  = out_wait_q;
    out_span_d  = out_span_q;
    out_count_d = out_count_q;
    out_ins_d   = out_ins_q;
    out_ovf_d   = out_ovf_q;
    act         = sdq_pkg::ACT_HOLD;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          now_d      = now_tick_i;
          res_wait_d = '0;
          res_span_d = '0;
          res_ins_d  = 1'b0;
          res_ovf_d  = 1'b0;
          unique case (sdq_pkg::opcode_e'(opcode_i))
            sdq_pkg::OP_REQUEST: begin
              state_d = S_CALC;
            end
            sdq_pkg::OP_QUERY: begin
              if (!valid_w[0]) begin
                res_wait_d = empty_wait_q;
              end else if (!head_span_in[W-1]) begin
                res_wait_d = head_span_in;
              end
              state_d = S_DONE;
            end
            sdq_pkg::OP_POP: begin
              res_span_d = empty_wait_q;
              state_d    = S_POP;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CALC: begin
        if (calc_done) begin
          state_d = S_REQ;
        end
      end
      S_REQ: begin
        unique case (scan_w[DEPTH].kind)
          sdq_pkg::HIT_EXP: begin
            act     = sdq_pkg::ACT_REMOVE;
            count_d = count_q - CW'(1);
          end
          sdq_pkg::HIT_EQ: begin
            state_d = S_DONE;
          end
          sdq_pkg::HIT_GT,
          sdq_pkg::HIT_END: begin
            if (full) begin
              res_ovf_d = 1'b1;
            end else begin
              act       = sdq_pkg::ACT_INSERT;
              count_d   = count_q + CW'(1);
              res_ins_d = 1'b1;
            end
            state_d = S_DONE;
          end
          default: begin
            res_ovf_d = 1'b1;
            state_d   = S_DONE;
          end
        endcase
      end
      S_POP: begin
        unique case (scan_w[DEPTH].kind)
          sdq_pkg::HIT_EXP: begin
            act        = sdq_pkg::ACT_REMOVE;
            count_d    = count_q - CW'(1);
            res_span_d = head_span;
          end
          sdq_pkg::HIT_STOP: begin
            res_span_d = head_span;
            state_d    = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_wait_d  = res_wait_q;
          out_span_d  = res_span_q;
          out_count_d = 5'(count_q);
          out_ins_d   = res_ins_q;
          out_ovf_d   = res_ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      res_wait_q  <= '0;
      res_span_q  <= '0;
      res_ins_q   <= 1'b0;
      res_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_wait_q  <= '0;
      out_span_q  <= '0;
      out_count_q <= '0;
      out_ins_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      now_q       <= now_d;
      res_wait_q  <= res_wait_d;
      res_span_q  <= res_span_d;
      res_ins_q   <= res_ins_d;
      res_ovf_q   <= res_ovf_d;
      out_valid_q <= out_valid_d;
      out_wait_q  <= out_wait_d;
      out_span_q  <= out_span_d;
      out_count_q <= out_count_d;
      out_ins_q   <= out_ins_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign wait_ticks_o  = out_wait_q;
  assign last_span_o   = signed'(out_span_q);
  assign entry_count_o = out_count_q;
  assign inserted_o    = out_ins_q;
  assign overflow_o    = out_ovf_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the sorted deadline queue, with its own queue predictor
`default_nettype none

module tb;

  localparam int unsigned TickW        = sdq_pkg::TickW;
  localparam int unsigned Depth        = 16;
  localparam int unsigned TickPeriodMs = 10;

  typedef struct packed {
    sdq_pkg::opcode_e op;
    logic [TickW-1:0] now;
    logic [TickW-1:0] dly;
  } wake_cmd_t;

  typedef struct packed {
    logic [TickW-1:0] wait_ticks;
    logic [TickW-1:0] span;
    logic [4:0]       count;
    logic             ins;
    logic             ovf;
  } wake_result_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [31:0]       cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        opcode_i      = '0;
  logic [31:0]       now_tick_i    = '0;
  logic [31:0]       delay_ms_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [31:0]       wait_ticks_o;
  logic signed [31:0] last_span_o;
  logic [4:0]        entry_count_o;
  logic              inserted_o;
  logic              overflow_o;

  sorted_deadline_queue #(
    .DEPTH          (Depth),
    .TICK_PERIOD_MS (TickPeriodMs)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .now_tick_i    (now_tick_i),
    .delay_ms_i    (delay_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .wait_ticks_o  (wait_ticks_o),
    .last_span_o   (last_span_o),
    .entry_count_o (entry_count_o),
    .inserted_o    (inserted_o),
    .overflow_o    (overflow_o)
  );

  // predictor state
  logic [TickW-1:0] deadline_list [Depth];
  int unsigned      held_count     = 0;
  logic [TickW-1:0] empty_wait_cfg = 32'd100;

  wake_cmd_t    pending_cmds [$];
  wake_result_t expected_results [$];
  wake_cmd_t    offered;
  wake_result_t head_result;

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  beats_sent     = 0;
  int  stored_cnt     = 0;
  int  full_cnt       = 0;
  int  repeat_cnt     = 0;
  int  expired_cnt    = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  calm_stretch   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void drop_entry(input int unsigned idx);
    int unsigned j;
    for (j = idx; j + 1 < held_count; j++) deadline_list[j] = deadline_list[j + 1];
    held_count--;
    expired_cnt++;
  endfunction

  function automatic wake_result_t step_queue(input wake_cmd_t c);
    wake_result_t     r;
    logic [63:0]      quot;
    logic [TickW-1:0] nxt;
    logic [TickW-1:0] gap;
    int unsigned      pos;
    int unsigned      j;
    bit               dup;
    bit               halt;
    r    = '0;
    pos  = 0;
    dup  = 1'b0;
    halt = 1'b0;
    case (c.op)
      sdq_pkg::OP_REQUEST: begin
        quot = ({32'd0, c.dly} + TickPeriodMs - 1) / TickPeriodMs;
        nxt  = c.now + quot[TickW-1:0];
        while (pos < held_count && !halt) begin
          gap = deadline_list[pos] - c.now;
          if (gap[TickW-1]) begin
            drop_entry(pos);
          end else if (deadline_list[pos] == nxt) begin
            dup  = 1'b1;
            halt = 1'b1;
          end else begin
            gap = deadline_list[pos] - nxt;
            if (gap != 0 && !gap[TickW-1]) halt = 1'b1;
            else pos++;
          end
        end
        if (dup) begin
          repeat_cnt++;
        end else if (held_count >= Depth) begin
          r.ovf = 1'b1;
          full_cnt++;
        end else begin
          for (j = held_count; j > pos; j--) deadline_list[j] = deadline_list[j - 1];
          deadline_list[pos] = nxt;
          held_count++;
          r.ins = 1'b1;
          stored_cnt++;
        end
      end
      sdq_pkg::OP_QUERY: begin
        if (held_count == 0) begin
          r.wait_ticks = empty_wait_cfg;
        end else begin
          gap = deadline_list[0] - c.now;
          r.wait_ticks = gap[TickW-1] ? '0 : gap;
        end
      end
      sdq_pkg::OP_POP: begin
        r.span = empty_wait_cfg;
        while (held_count > 0 && !halt) begin
          r.span = deadline_list[0] - c.now;
          if (r.span == 0 || r.span[TickW-1]) drop_entry(0);
          else halt = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = held_count[4:0];
    return r;
  endfunction

  function automatic void add_cmd(input sdq_pkg::opcode_e op, input logic [31:0] now,
                                  input logic [31:0] dly);
    wake_cmd_t c;
    c.op  = op;
    c.now = now;
    c.dly = dly;
    pending_cmds.push_back(c);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_results.push_back(step_queue(offered));
        beats_sent++;
      end
      if (pending_cmds.size() != 0 && (calm_stretch || $urandom_range(0, 99) >= 17)) begin
        offered = pending_cmds[0];
        pending_cmds.delete(0);
        in_valid_i <= 1'b1;
        opcode_i   <= offered.op;
        now_tick_i <= offered.now;
        delay_ms_i <= offered.dly;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && results_seen >= 250) begin
      hold_left   <= 400;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm_stretch || ($urandom_range(0, 99) >= 17);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing pending: wait %h span %h count %0d",
                   wait_ticks_o, last_span_o, entry_count_o);
      end else begin
        head_result = expected_results[0];
        expected_results.delete(0);
        check_field("wait_ticks", head_result.wait_ticks, wait_ticks_o);
        check_field("last_span", head_result.span, last_span_o);
        check_field("entry_count", {27'd0, head_result.count}, {27'd0, entry_count_o});
        check_field("inserted", {31'd0, head_result.ins}, {31'd0, inserted_o});
        check_field("overflow", {31'd0, head_result.ovf}, {31'd0, overflow_o});
      end
    end
  end

  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_empty_wait(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    empty_wait_cfg = v;
  endtask

  task automatic run_traffic(input int n, input logic [31:0] start);
    logic [31:0] tick;
    int          made;
    int          k;
    int          roll;
    tick = start;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // distinct deadlines in a row, enough to fill the store
        for (k = 0; k < 18; k++)
          add_cmd(sdq_pkg::OP_REQUEST, tick, 10 * k + $urandom_range(1, 10));
        made += 18;
      end else if (roll < 6) begin
        if ($urandom_range(0, 7) == 0) tick += $urandom;
        else tick += $urandom_range(20, 60);
        add_cmd(sdq_pkg::OP_POP, tick, $urandom);
        made++;
      end else if (roll < 9) begin
        add_cmd(sdq_pkg::opcode_e'($urandom_range(0, 3)), $urandom, $urandom);
        made++;
      end else begin
        tick += $urandom_range(0, 3);
        roll = $urandom_range(0, 99);
        if (roll < 45)
          add_cmd(sdq_pkg::OP_REQUEST, tick,
                  ($urandom_range(0, 39) == 0) ? $urandom : $urandom_range(0, 300));
        else if (roll < 65) add_cmd(sdq_pkg::OP_QUERY, tick, $urandom);
        else if (roll < 90) add_cmd(sdq_pkg::OP_POP, tick, $urandom);
        else add_cmd(sdq_pkg::OP_IDLE, tick, $urandom);
        made++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_cmd(sdq_pkg::OP_QUERY, 32'd0, 32'd0);
    add_cmd(sdq_pkg::OP_POP, 32'd0, 32'hFFFF_FFFF);
    add_cmd(sdq_pkg::OP_IDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(sdq_pkg::OP_REQUEST, 32'd0, 32'd0);
    add_cmd(sdq_pkg::OP_REQUEST, 32'd0, 32'd0);
    add_cmd(sdq_pkg::OP_QUERY, 32'd0, 32'd0);
    add_cmd(sdq_pkg::OP_REQUEST, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    add_cmd(sdq_pkg::OP_REQUEST, 32'hFFFF_FFF0, 32'd1);
    add_cmd(sdq_pkg::OP_QUERY, 32'hFFFF_FFF8, 32'd0);
    add_cmd(sdq_pkg::OP_POP, 32'hFFFF_FFF8, 32'd0);
    add_cmd(sdq_pkg::OP_REQUEST, 32'd5, 32'd10);
    add_cmd(sdq_pkg::OP_REQUEST, 32'd5, 32'd11);
    add_cmd(sdq_pkg::OP_REQUEST, 32'd5, 32'd9);
    add_cmd(sdq_pkg::OP_POP, 32'd6, 32'd0);
    add_cmd(sdq_pkg::OP_QUERY, 32'h8000_0007, 32'd0);
    add_cmd(sdq_pkg::OP_REQUEST, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(sdq_pkg::OP_POP, 32'h8000_0006, 32'd0);
    add_cmd(sdq_pkg::OP_QUERY, 32'd2, 32'd0);
    settle();

    set_empty_wait(32'd0);
    run_traffic(320, $urandom);
    settle();

    // no idling on either side for this stretch
    set_empty_wait(32'hFFFF_FFFF);
    calm_stretch <= 1'b1;
    run_traffic(320, 32'hFFFF_F000);
    settle();
    calm_stretch <= 1'b0;

    set_empty_wait(32'h8000_0000);
    run_traffic(320, $urandom);
    settle();

    set_empty_wait($urandom);
    run_traffic(320, 32'h7FFF_FF00);
    settle();

    set_empty_wait(32'd1);
    run_traffic(320, $urandom);
    settle();
    repeat (32) @(posedge clk_i);

    $display("covered %0d beats over six empty_wait settings, with a long output hold",
             beats_sent);
    $display("%0d deadlines stored, %0d rejected when full, %0d repeats, %0d expired",
             stored_cnt, full_cnt, repeat_cnt, expired_cnt);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("sorted_deadline_queue test passed");
    end else begin
      $display("sorted_deadline_queue test failed");
    end
    $finish;
  end

  initial begin
    #(8 * 600000);
    $display("sorted_deadline_queue test failed");
    $finish;
  end

endmodule

`default_nettype wire
